@@ rtl/core/gfsf_pkg.sv @@
// Shared constants, types and controller/datapath command struct for the
// GPS fix speed filter. No dependencies.
package gfsf_pkg;
    localparam int WINDOW   = 4;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SEG_W    = 26;
    localparam int SUM_W    = SEG_W + $clog2(WINDOW + 1);
    localparam int SQ_W     = 52;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int DIV_W    = 48;
    localparam int SEG_MAX  = 26'h3FFFFFF;
    localparam int VMAX     = 100000;
    localparam int HMAX     = 1000000;

    // ceil(2^35 * 1.852): segment metres = (root * SEG_RECIP) >> 35
    localparam logic [35:0] SEG_RECIP = 36'hED0E56042;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SQRT     = 9'b000000010,
        ST_SCALE_LO = 9'b000000100,
        ST_SCALE_HI = 9'b000001000,
        ST_SEG      = 9'b000010000,
        ST_VDIV     = 9'b000100000,
        ST_HDIV     = 9'b001000000,
        ST_DONE     = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic scale_lo;
        logic scale_hi;
        logic seg_commit;
        logic vdiv_start;
        logic hdiv_start;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } sts_t;
endpackage

@@ rtl/core/gfsf_ctrl.sv @@
// Sequencer for the GPS fix speed filter.
// Depends on gfsf_pkg; drives the datapath by cmd_t, reads sts_t.
module gfsf_ctrl import gfsf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_fire,
    input  logic out_fire,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_ready,
    output logic out_valid
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_fire;
                if (in_fire) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done) state_next = ST_SCALE_LO;
            end
            ST_SCALE_LO: begin
                cmd.scale_lo = 1'b1;
                state_next = ST_SCALE_HI;
            end
            ST_SCALE_HI: begin
                cmd.scale_hi = 1'b1;
                state_next = ST_SEG;
            end
            ST_SEG: begin
                cmd.seg_commit = 1'b1;
                cmd.vdiv_start = 1'b1;
                state_next = ST_VDIV;
            end
            ST_VDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    cmd.hdiv_start = 1'b1;
                    state_next = ST_HDIV;
                end
            end
            ST_HDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE) && aresetn;
    assign out_valid = (state_reg == ST_OUT);
endmodule

@@ rtl/core/gfsf_datapath.sv @@
// Rings, square root and shared restoring divider of the speed filter.
// Depends on gfsf_pkg; commanded by gfsf_ctrl.
module gfsf_datapath import gfsf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [19:0]         cfg_data,
    input  logic                cfg_we,
    input  logic [16:0]         fix_time,
    input  logic signed [23:0]  lat,
    input  logic signed [24:0]  lon,
    input  logic signed [17:0]  alt,
    output logic signed [17:0]  vert_speed,
    output logic [19:0]         hor_speed,
    output logic                window_valid,
    output logic                saturated
);
    logic [19:0]        dflt_reg;
    logic [16:0]        time_reg [WINDOW+1];
    logic signed [17:0] alt_reg  [WINDOW+1];
    logic [SEG_W-1:0]   seg_reg  [WINDOW];
    logic signed [23:0] plat_reg;
    logic signed [24:0] plon_reg;
    logic [16:0]        time_in_reg;
    logic signed [17:0] alt_in_reg;
    logic signed [23:0] lat_in_reg;
    logic signed [24:0] lon_in_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               first_reg, full_reg;
    logic [SQ_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [4:0]         sstep_reg;
    logic [43:0]        slo_reg;
    logic [SEG_W-1:0]   segv_reg;
    logic [DIV_W-1:0]   num_reg, quo_reg;
    logic [DIV_W:0]     drem_reg;
    logic [16:0]        den_reg;
    logic [5:0]         dstep_reg;
    logic               vneg_reg;
    logic [DIV_W-1:0]   vquo_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [16:0]        dt_reg;
    logic               dtpos_reg;

    logic signed [24:0] dlat;
    logic signed [25:0] dlon;
    logic [SQ_W-1:0]    sq_next;
    logic [ROOT_W+1:0]  trial;
    logic [SQ_W-1:0]    rem_sh;
    logic [61:0]        seg_prod;
    logic [26:0]        seg_full;
    logic [SUM_W-1:0]   sum_next;
    logic [DIV_W:0]     drem_sh;
    logic signed [18:0] dalt;
    logic [18:0]        dalt_abs;
    logic signed [17:0] dt_s;
    logic [19:0]        dflt_c;

    assign dlat = 25'(lat) - 25'(plat_reg);
    assign dlon = 26'(lon) - 26'(plon_reg);
    assign sq_next = SQ_W'(50'(unsigned'(48'(dlat * dlat)))) +
                     SQ_W'(unsigned'(52'(dlon * dlon)));
    assign rem_sh = {rem_reg[SQ_W-3:0], sq_reg[SQ_W-1:SQ_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign seg_prod = {44'(root_reg) * 44'(SEG_RECIP[35:18]), 18'b0} + 62'(slo_reg);
    assign seg_full = seg_prod[61:35];
    assign dt_s = 18'(time_in_reg) - 18'(time_reg[WINDOW-1]);
    assign dalt = 19'(alt_in_reg) - 19'(alt_reg[WINDOW-1]);
    assign dalt_abs = dalt[18] ? 19'(-dalt) : 19'(dalt);
    assign drem_sh = {drem_reg[DIV_W-1:0], num_reg[DIV_W-1]};
    assign dflt_c = (dflt_reg > 20'(HMAX)) ? 20'(HMAX) : dflt_reg;

    always_comb begin
        sum_next = SUM_W'(segv_reg);
        for (int k = 0; k < WINDOW - 1; k++) sum_next = sum_next + SUM_W'(seg_reg[k]);
    end

    assign sts.sqrt_done = (sstep_reg == 5'(ROOT_W - 1));
    assign sts.div_done  = (dstep_reg == 6'(DIV_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg <= 20'd12000;
            cnt_reg  <= '0;
            plat_reg <= '0;
            plon_reg <= '0;
            for (int k = 0; k <= WINDOW; k++) begin
                time_reg[k] <= '0;
                alt_reg[k]  <= '0;
            end
            for (int k = 0; k < WINDOW; k++) seg_reg[k] <= '0;
        end else begin
            if (cfg_we) dflt_reg <= cfg_data;
            if (cmd.seg_commit) begin
                for (int k = WINDOW; k > 0; k--) begin
                    time_reg[k] <= time_reg[k-1];
                    alt_reg[k]  <= alt_reg[k-1];
                end
                time_reg[0] <= time_in_reg;
                alt_reg[0]  <= alt_in_reg;
                for (int k = WINDOW - 1; k > 0; k--) seg_reg[k] <= seg_reg[k-1];
                seg_reg[0] <= first_reg ? '0 : segv_reg;
                plat_reg <= lat_in_reg;
                plon_reg <= lon_in_reg;
                if (cnt_reg < CNT_W'(WINDOW)) cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sq_reg      <= sq_next;
            rem_reg     <= '0;
            root_reg    <= '0;
            sstep_reg   <= '0;
            first_reg   <= (cnt_reg == '0);
            full_reg    <= (cnt_reg >= CNT_W'(WINDOW));
            time_in_reg <= fix_time;
            alt_in_reg  <= alt;
            lat_in_reg  <= lat;
            lon_in_reg  <= lon;
        end else if (cmd.sqrt_step) begin
            sq_reg    <= {sq_reg[SQ_W-3:0], 2'b00};
            sstep_reg <= sstep_reg + 5'd1;
            if (rem_sh >= SQ_W'(trial)) begin
                rem_reg  <= rem_sh - SQ_W'(trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.scale_lo) slo_reg <= 44'(root_reg) * 44'(SEG_RECIP[17:0]);
        if (cmd.scale_hi) begin
            segv_reg <= (seg_full > 27'(SEG_MAX)) ? SEG_W'(SEG_MAX) : seg_full[SEG_W-1:0];
        end
        if (cmd.vdiv_start) begin
            sum_reg   <= first_reg ? SUM_W'(0) : sum_next;
            dt_reg    <= dt_s[16:0];
            dtpos_reg <= !dt_s[17] && (dt_s != '0);
            vneg_reg  <= dalt[18];
            num_reg   <= DIV_W'(dalt_abs) * DIV_W'(1000);
            den_reg   <= dt_s[16:0];
            drem_reg  <= '0;
            dstep_reg <= '0;
        end else if (cmd.hdiv_start) begin
            vquo_reg  <= {quo_reg[DIV_W-2:0], !drem_sh[DIV_W] &&
                          (drem_sh >= (DIV_W+1)'(den_reg))};
            num_reg   <= DIV_W'(sum_reg) * DIV_W'(3600);
            drem_reg  <= '0;
            dstep_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg   <= {num_reg[DIV_W-2:0], 1'b0};
            dstep_reg <= dstep_reg + 6'd1;
            if (drem_sh >= (DIV_W+1)'(den_reg)) begin
                drem_reg <= drem_sh - (DIV_W+1)'(den_reg);
                quo_reg  <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                drem_reg <= drem_sh;
                quo_reg  <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.finish) begin
            vert_speed   <= '0;
            hor_speed    <= dflt_c;
            window_valid <= 1'b0;
            saturated    <= 1'b0;
            if (full_reg && dtpos_reg) begin
                window_valid <= 1'b1;
                if (vquo_reg > DIV_W'(VMAX)) begin
                    vert_speed <= vneg_reg ? -18'sd100000 : 18'sd100000;
                    saturated  <= 1'b1;
                end else begin
                    vert_speed <= vneg_reg ? -18'(vquo_reg) : 18'(vquo_reg);
                end
                if (sum_reg != '0) begin
                    if (quo_reg > DIV_W'(HMAX)) begin
                        hor_speed <= 20'(HMAX);
                        saturated <= 1'b1;
                    end else begin
                        hor_speed <= 20'(quo_reg);
                    end
                end
            end
        end
    end
endmodule

@@ rtl/core/gps_fix_speed_filter.sv @@
// Top level of the GPS fix speed filter: sequencer plus datapath.
// Depends on gfsf_pkg, gfsf_ctrl, gfsf_datapath.
//   channel   direction  handshake                 payload
//   s_        in         s_valid / s_ready          fix_time, lat, lon, altitude
//   m_        out        m_valid / m_ready          speeds, window_valid, saturated
//   cfg_      in         cfg_valid / cfg_ready      default_hor_speed
// m_valid rises after the square root, the low and high scaling steps, the commit
// and two passes of the shared divider. Hold s_ready and cfg_ready low until the
// result is taken; no new request is accepted while a result is pending, so
// m_ready stalls delay the next request.
// Reset is synchronous, active low, and clears the rings and the sequencer.
module gps_fix_speed_filter import gfsf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [16:0]        s_fix_time,
    input  logic signed [23:0] s_lat_milliminutes,
    input  logic signed [24:0] s_lon_milliminutes,
    input  logic signed [17:0] s_altitude_m,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_vert_speed,
    output logic [19:0]        m_hor_speed,
    output logic               m_window_valid,
    output logic               m_saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [19:0]        cfg_data
);
    cmd_t cmd;
    sts_t sts;
    logic in_fire, out_fire;

    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign cfg_ready = s_ready;

    gfsf_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_fire, .sts, .cmd,
        .in_ready(s_ready), .out_valid(m_valid)
    );

    gfsf_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .cfg_data, .cfg_we(cfg_valid && cfg_ready),
        .fix_time(s_fix_time), .lat(s_lat_milliminutes),
        .lon(s_lon_milliminutes), .alt(s_altitude_m),
        .vert_speed(m_vert_speed), .hor_speed(m_hor_speed),
        .window_valid(m_window_valid), .saturated(m_saturated)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_hor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hor_speed <= 20'(HMAX)) else $error("hor_speed out of range");
    a_sat_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> m_window_valid) else $error("saturated without window");
endmodule

@@ test/tb_top.sv @@
// Self-checking bench for gps_fix_speed_filter: random fixes in, speeds compared
// against an in-bench window predictor. Depends on gfsf_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_top import gfsf_pkg::*;;

    localparam int CYCLE_CAP = 5000000;
    localparam int DRAIN     = 300;

    typedef struct packed {
        logic [16:0]        fix_time;
        logic signed [23:0] lat;
        logic signed [24:0] lon;
        logic signed [17:0] alt;
    } fix_t;

    typedef struct packed {
        logic signed [17:0] vert;
        logic [19:0]        hor;
        logic               valid;
        logic               sat;
    } speed_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [16:0] s_fix_time = '0;
    logic signed [23:0] s_lat_milliminutes = '0;
    logic signed [24:0] s_lon_milliminutes = '0;
    logic signed [17:0] s_altitude_m = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [17:0] m_vert_speed;
    logic [19:0] m_hor_speed;
    logic m_window_valid;
    logic m_saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [19:0] cfg_data = '0;

    gps_fix_speed_filter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_fix_time(s_fix_time), .s_lat_milliminutes(s_lat_milliminutes),
        .s_lon_milliminutes(s_lon_milliminutes), .s_altitude_m(s_altitude_m),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vert_speed(m_vert_speed), .m_hor_speed(m_hor_speed),
        .m_window_valid(m_window_valid), .m_saturated(m_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fix_t   pending_fixes[$];
    speed_t expected_speeds[$];
    int     errors = 0;
    int     cycles = 0;
    int     n_sent = 0;
    int     n_issued = 0;
    int     n_checked = 0;
    int     n_valid_win = 0;
    int     n_sat = 0;

    // predictor state
    logic [19:0]  dflt_speed = 20'd12000;
    logic [16:0]  t_hist[WINDOW+1];
    logic signed [17:0] a_hist[WINDOW+1];
    logic [25:0]  seg_hist[WINDOW];
    logic signed [23:0] last_lat;
    logic signed [24:0] last_lon;
    int           fixes_seen;

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic speed_t predict_speed(fix_t f);
        speed_t o;
        longint dl, dn, dt, v, lim;
        longint unsigned sq, seg, sum, h;
        bit full;
        lim = (dflt_speed > HMAX) ? HMAX : dflt_speed;
        o.vert = '0;
        o.hor = lim[19:0];
        o.valid = 1'b0;
        o.sat = 1'b0;
        full = fixes_seen >= WINDOW;
        seg = 0;
        if (fixes_seen > 0) begin
            dl = longint'(f.lat) - longint'(last_lat);
            dn = longint'(f.lon) - longint'(last_lon);
            sq = longint'(dl * dl) + longint'(dn * dn);
            seg = (root64(sq) * 1852) / 1000;
            if (seg > 64'h3FFFFFF) seg = 64'h3FFFFFF;
        end
        for (int k = WINDOW; k > 0; k--) begin
            t_hist[k] = t_hist[k-1];
            a_hist[k] = a_hist[k-1];
        end
        t_hist[0] = f.fix_time;
        a_hist[0] = f.alt;
        for (int k = WINDOW - 1; k > 0; k--) seg_hist[k] = seg_hist[k-1];
        seg_hist[0] = seg[25:0];
        last_lat = f.lat;
        last_lon = f.lon;
        if (fixes_seen < WINDOW) fixes_seen++;
        if (full) begin
            dt = longint'(t_hist[0]) - longint'(t_hist[WINDOW]);
            if (dt > 0) begin
                o.valid = 1'b1;
                v = ((longint'(a_hist[0]) - longint'(a_hist[WINDOW])) * 1000) / dt;
                if (v > VMAX) begin v = VMAX; o.sat = 1'b1; end
                if (v < -VMAX) begin v = -VMAX; o.sat = 1'b1; end
                o.vert = v[17:0];
                sum = 0;
                for (int k = 0; k < WINDOW; k++) sum += seg_hist[k];
                if (sum > 0) begin
                    h = (sum * 3600) / longint'(dt);
                    if (h > HMAX) begin h = HMAX; o.sat = 1'b1; end
                    o.hor = h[19:0];
                end
            end
        end
        return o;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // driver: hold the request until the monitor has counted it as taken
    int s_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            bit s_busy;
            s_busy = s_valid && (n_sent != n_issued);
            if (!s_busy) begin
                if (s_valid) s_gap = gap_len();
                if (s_gap == 0 && pending_fixes.size() > 0) begin
                    fix_t f;
                    f = pending_fixes.pop_front();
                    s_fix_time <= f.fix_time;
                    s_lat_milliminutes <= f.lat;
                    s_lon_milliminutes <= f.lon;
                    s_altitude_m <= f.alt;
                    s_valid <= 1'b1;
                    n_issued++;
                end else begin
                    s_valid <= 1'b0;
                    if (s_gap > 0) s_gap--;
                end
            end
        end
    end

    // accept stall pattern on the result side
    int m_gap = 0;
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) m_gap = gap_len();
        end
    end

    // monitor: predict on accepted requests, compare accepted results
    always @(posedge aclk) begin
        cycles++;
        if (aresetn && s_valid && s_ready) begin
            fix_t f;
            f = '{s_fix_time, s_lat_milliminutes, s_lon_milliminutes, s_altitude_m};
            expected_speeds = {expected_speeds, predict_speed(f)};
            n_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            speed_t got, exp_s;
            got = '{m_vert_speed, m_hor_speed, m_window_valid, m_saturated};
            if (expected_speeds.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                exp_s = expected_speeds.pop_front();
                n_checked++;
                if (exp_s.valid) n_valid_win++;
                if (exp_s.sat) n_sat++;
                if (got.vert !== exp_s.vert)
                    $display("%0t: vert_speed expected %0d got %0d", $time, exp_s.vert, got.vert);
                if (got.hor !== exp_s.hor)
                    $display("%0t: hor_speed expected %0d got %0d", $time, exp_s.hor, got.hor);
                if (got.valid !== exp_s.valid)
                    $display("%0t: window_valid expected %0b got %0b", $time,
                             exp_s.valid, got.valid);
                if (got.sat !== exp_s.sat)
                    $display("%0t: saturated expected %0b got %0b", $time, exp_s.sat, got.sat);
                if (got !== exp_s) errors++;
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_default(input logic [19:0] v);
        @(negedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        dflt_speed = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_fixes.size() > 0 || s_valid || expected_speeds.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic push_fix(input int t, input int la, input int lo, input int al);
        fix_t f;
        f.fix_time = t[16:0];
        f.lat = la[23:0];
        f.lon = lo[24:0];
        f.alt = al[17:0];
        pending_fixes = {pending_fixes, f};
    endtask

    // random track: time mostly increasing with repeats, jumps and day wrap; small moves with rare large jumps
    task automatic push_track(input int len, inout int t, inout int la, inout int lo,
                              inout int al);
        for (int i = 0; i < len; i++) begin
            int r;
            r = $urandom_range(0, 19);
            if (r == 0) t = t;
            else if (r == 1) t = $urandom_range(0, 86399);
            else t = t + $urandom_range(1, 3);
            if (t > 86399) t = t - 86400;
            la = la + $signed($urandom_range(0, 4000)) - 2000;
            lo = lo + $signed($urandom_range(0, 4000)) - 2000;
            if ($urandom_range(0, 9) == 0) lo = lo + $signed($urandom_range(0, 400000)) - 200000;
            al = al + $signed($urandom_range(0, 60)) - 30;
            if ($urandom_range(0, 29) == 0) al = al + $signed($urandom_range(0, 2000)) - 1000;
            if (la > 5400000) la = 5400000;
            if (la < -5400000) la = -5400000;
            if (lo > 10800000) lo = 10800000;
            if (lo < -10800000) lo = -10800000;
            if (al > 99999) al = 99999;
            if (al < -9999) al = -9999;
            push_fix(t, la, lo, al);
        end
    endtask

    initial begin
        int t, la, lo, al;
        for (int k = 0; k <= WINDOW; k++) begin t_hist[k] = '0; a_hist[k] = '0; end
        for (int k = 0; k < WINDOW; k++) seg_hist[k] = '0;
        last_lat = '0;
        last_lon = '0;
        fixes_seen = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: not-full window, zero distance, extremes, wrap, saturation
        push_fix(0, 0, 0, 0);
        push_fix(1, 0, 0, 0);
        push_fix(2, 0, 0, 0);
        push_fix(3, 0, 0, 0);
        push_fix(4, 0, 0, 99999);
        push_fix(5, 5400000, 10800000, -9999);
        push_fix(6, -5400000, -10800000, 99999);
        push_fix(86399, 5400000, 10800000, 0);
        push_fix(10, 0, 0, 0);
        push_fix(10, 0, 0, 0);
        push_fix(11, 100, 0, 0);
        push_fix(12, 200, 0, 0);
        push_fix(13, 300, 0, 0);
        push_fix(14, 400, 0, 0);
        push_fix(131071, -8388608, -16777216, -131072);
        push_fix(0, 8388607, 16777215, 131071);
        push_fix(1, -8388608, -16777216, -131072);
        push_fix(2, 8388607, 16777215, 131071);
        push_fix(3, 0, 0, 0);
        settle();

        write_default(20'hFFFFF);
        push_fix(100, 0, 0, 5);
        push_fix(101, 0, 0, 5);
        push_fix(102, 0, 0, 5);
        push_fix(103, 0, 0, 5);
        push_fix(104, 0, 0, 5);
        settle();

        write_default(20'd0);
        t = 1000; la = 0; lo = 0; al = 100;
        push_track(400, t, la, lo, al);
        settle();

        write_default(20'd1000000);
        t = 40000; la = -3000000; lo = 5000000; al = 2000;
        for (int n = 0; n < 40; n++) begin
            push_track(8, t, la, lo, al);
            if ($urandom_range(0, 3) == 0) begin
                fix_t f;
                f = fix_t'(84'({$urandom, $urandom, $urandom}));
                pending_fixes = {pending_fixes, f};
            end
        end
        settle();

        write_default(20'($urandom_range(0, 1048575)));
        t = 70000; la = 1000000; lo = -2000000; al = 500;
        push_track(480, t, la, lo, al);
        settle();

        $display("fixes sent %0d, results checked %0d, full windows %0d, clipped %0d",
                 n_sent, n_checked, n_valid_win, n_sat);
        $display("defaults 12000, max, 0, 1000000 and random were exercised");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/gfsf_pkg.sv
rtl/core/gfsf_ctrl.sv
rtl/core/gfsf_datapath.sv
rtl/core/gps_fix_speed_filter.sv
test/tb_top.sv
